FILE: hdl/b64lw_pkg.sv
// package for the base64 line-wrap encoder
// holds the queue word type, character constants and the alphabet lookup
`timescale 1ns / 1ps

package b64lw_pkg;

    // configuration register indexes
    localparam logic REG_LINE_LIMIT = 1'b0;
    localparam logic REG_EOL_MODE   = 1'b1;

    // reset values of the configuration registers
    localparam logic [7:0] LINE_LIMIT_RESET = 8'd76;
    localparam logic       EOL_MODE_RESET   = 1'b1;

    // special characters
    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] CR_CHAR  = 8'h0D;
    localparam logic [7:0] LF_CHAR  = 8'h0A;

    // most characters one byte can cause
    localparam int MAX_CHARS = 8;

    // one queue word: all characters caused by one byte
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [3:0]                count;
        logic                      fin;
    } job_t;

    // queue status seen by the back end
    typedef struct packed {
        logic full;
        logic head_valid;
    } q_stat_t;

    // six-bit value to base64 symbol
    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] r;
        begin
            w = {2'b00, v};
            if (v < 6'd26)
                r = 8'h41 + w;
            else if (v < 6'd52)
                r = 8'h61 + w - 8'd26;
            else if (v < 6'd62)
                r = 8'h30 + w - 8'd52;
            else if (v == 6'd62)
                r = 8'h2B;
            else
                r = 8'h2F;
            return r;
        end
    endfunction

endpackage

FILE: hdl/base64_line_wrap_encoder.sv
// base64 encoder with line wrapping: one byte in, base64 text out a character at a time
// the first character of a word passes through a queue entry and then the output register
// throughput: one character per cycle unless the output stalls; a byte that completes or ends
// a group gives four to eight characters, a held byte gives none
// the two-entry queue lets bytes enter while earlier characters drain
// reset (rst_n low, asynchronous): line limit 76, CR LF line ends, group and line cleared
`timescale 1ns / 1ps

module base64_line_wrap_encoder
    import b64lw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       message_end,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    job_t    push_job;
    job_t    head_job;

    // byte intake and grouping
    b64lw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_stat     (q_stat),
        .push       (push),
        .push_job   (push_job)
    );

    // word queue
    b64lw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // character output
    b64lw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .q_stat      (q_stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .message_end (message_end)
    );

    // no write into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    // a word leaves the queue only when one is there
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.head_valid)
        else $error("pop from empty queue");

    // message end only on the last character of a word
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && message_end) |-> run_last)
        else $error("message end without run end");

    // a pop loads a character into the output register
    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && run_last))
        else $error("pop without a last character");

endmodule

FILE: hdl/b64lw_front.sv
// front end: accepts bytes, holds the partial group and line count,
// and builds one queue word per byte that causes output; uses b64lw_pkg
`timescale 1ns / 1ps

module b64lw_front
    import b64lw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  q_stat_t    q_stat,
    output logic       push,
    output job_t       push_job
);

    logic [7:0]  line_limit_reg;
    logic        eol_mode_reg;
    logic [15:0] pending_reg, pending_next;
    logic [1:0]  fill_reg, fill_next;
    logic [7:0]  line_count_reg, line_count_next;

    logic       accept;
    logic       full_group;
    logic [7:0] c1, c2;
    logic [7:0] lc_sum;
    logic [7:0] thr;
    logic       wrap;
    logic [1:0] eol_len;
    logic [1:0] eol_cnt;

    assign in_stall = q_stat.full;
    assign accept   = in_valid & ~q_stat.full;

    assign c1         = pending_reg[15:8];
    assign c2         = pending_reg[7:0];
    assign full_group = (fill_reg >= 2'd2);
    assign lc_sum     = line_count_reg + 8'd4;
    assign thr        = (line_limit_reg > 8'd3) ? line_limit_reg - 8'd3 : 8'd0;
    assign wrap       = full_group & (lc_sum >= thr);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= LINE_LIMIT_RESET;
            eol_mode_reg   <= EOL_MODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_LINE_LIMIT: line_limit_reg <= cfg_data;
                REG_EOL_MODE:   eol_mode_reg   <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // queue word: four group characters, then wrap and closing line ends
    always_comb
    begin
        push_job = '0;
        if (full_group)
        begin
            push_job.chars[0] = b64_sym(c1[7:2]);
            push_job.chars[1] = b64_sym({c1[1:0], c2[7:4]});
            push_job.chars[2] = b64_sym({c2[3:0], data_byte[7:6]});
            push_job.chars[3] = b64_sym(data_byte[5:0]);
        end
        else if (fill_reg == 2'd0)
        begin
            push_job.chars[0] = b64_sym(data_byte[7:2]);
            push_job.chars[1] = b64_sym({data_byte[1:0], 4'b0000});
            push_job.chars[2] = PAD_CHAR;
            push_job.chars[3] = PAD_CHAR;
        end
        else
        begin
            push_job.chars[0] = b64_sym(c1[7:2]);
            push_job.chars[1] = b64_sym({c1[1:0], data_byte[7:4]});
            push_job.chars[2] = b64_sym({data_byte[3:0], 2'b00});
            push_job.chars[3] = PAD_CHAR;
        end
        // both line ends are the same sequence, so the tail is a repeat
        push_job.chars[4] = eol_mode_reg ? CR_CHAR : LF_CHAR;
        push_job.chars[5] = LF_CHAR;
        push_job.chars[6] = CR_CHAR;
        push_job.chars[7] = LF_CHAR;
        eol_len = eol_mode_reg ? 2'd2 : 2'd1;
        eol_cnt = {1'b0, wrap} + {1'b0, final_byte};
        push_job.count = 4'd4 + ({2'b00, eol_cnt} * {2'b00, eol_len});
        push_job.fin   = final_byte;
    end

    assign push = accept & (full_group | final_byte);

    // group and line state
    always_comb
    begin
        pending_next    = pending_reg;
        fill_next       = fill_reg;
        line_count_next = line_count_reg;
        if (accept)
        begin
            if (final_byte)
            begin
                pending_next    = '0;
                fill_next       = '0;
                line_count_next = '0;
            end
            else if (full_group)
            begin
                pending_next    = '0;
                fill_next       = '0;
                line_count_next = wrap ? 8'd0 : lc_sum;
            end
            else
            begin
                if (fill_reg == 2'd0)
                    pending_next = {data_byte, 8'h00};
                else
                    pending_next = {c1, data_byte};
                fill_next = fill_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            fill_reg       <= '0;
            line_count_reg <= '0;
        end
        else
        begin
            pending_reg    <= pending_next;
            fill_reg       <= fill_next;
            line_count_reg <= line_count_next;
        end
    end

endmodule

FILE: hdl/b64lw_queue.sv
// two-entry queue of words between front and back end
// uses job_t and q_stat_t from b64lw_pkg
`timescale 1ns / 1ps

module b64lw_queue
    import b64lw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head_job,
    output q_stat_t q_stat
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign q_stat.full       = (cnt_reg == 2'd2);
    assign q_stat.head_valid = (cnt_reg != 2'd0);
    assign head_job          = entry_reg[rd_ptr_reg];

    // pointers and fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: hdl/b64lw_back.sv
// back end: steps through the head word one character per cycle, unless the output stalls,
// into the output register; uses job_t and q_stat_t from b64lw_pkg
`timescale 1ns / 1ps

module b64lw_back
    import b64lw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head_job,
    input  q_stat_t    q_stat,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       message_end
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       run_last_reg;
    logic       message_end_reg;

    logic       load;
    logic       last;
    logic [3:0] last_idx;

    assign load     = q_stat.head_valid & (~out_valid_reg | ~out_stall);
    assign last_idx = head_job.count - 4'd1;
    assign last     = ({1'b0, idx_reg} == last_idx);
    assign pop      = load & last;

    // character index and output valid
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last ? 3'd0 : idx_reg + 3'd1;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg    <= head_job.chars[idx_reg];
            run_last_reg    <= last;
            message_end_reg <= last & head_job.fin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign run_last    = run_last_reg;
    assign message_end = message_end_reg;

endmodule

FILE: dv/base64_line_wrap_encoder_tb.sv
// testbench for the base64 line-wrap encoder: directed table, then random messages
// predicts every character word in-house and checks it; needs hdl/b64lw_pkg.sv and the rtl
`timescale 1ns / 1ps

module base64_line_wrap_encoder_tb;
    import b64lw_pkg::*;

    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       msg_end;
    } text_word_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_REG
    } row_kind_e;

    typedef struct packed {
        row_kind_e  kind;
        logic [7:0] val;
        logic       flag;   // final marker for a byte, register index for a write
    } stim_row_t;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte   = 8'h00;
    logic       final_byte  = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] out_char;
    logic       run_last;
    logic       message_end;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_index   = REG_LINE_LIMIT;
    logic [7:0] cfg_data    = 8'h00;

    // predictor state and its copy of the registers
    logic [15:0] held_pair;
    logic [1:0]  held_cnt;
    logic [7:0]  line_chars;
    logic [7:0]  wrap_limit;
    logic        crlf_on;

    text_word_t  chars_due[$];
    logic [7:0]  group_text[$];
    stim_row_t   stim_rows[$];
    string       stim_text[$];
    int          mismatch_cnt = 0;
    int          burst_left   = 0;
    int          gap_max      = 0;
    int          stall_pct    = 0;
    int          stall_phase  = 0;

    base64_line_wrap_encoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .final_byte  (final_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .message_end (message_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // six-bit value to its alphabet character
    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        int idx;
        idx = v;
        return B64_ALPHABET[8*(63-idx) +: 8];
    endfunction

    task automatic push_line_end();
        if (crlf_on)
            group_text = {group_text, CR_CHAR};
        group_text = {group_text, LF_CHAR};
    endtask

    // work out the characters one accepted byte causes and queue them
    task automatic encode_byte(input logic [7:0] b, input logic fin, input string known);
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] thr;
        text_word_t w;
        int         i;
        c1 = held_pair[15:8];
        c2 = held_pair[7:0];
        thr = (wrap_limit > 8'd3) ? wrap_limit - 8'd3 : 8'd0;
        group_text.delete();
        if (held_cnt >= 2'd2)
        begin
            group_text = {group_text, alphabet_char(c1[7:2])};
            group_text = {group_text, alphabet_char({c1[1:0], c2[7:4]})};
            group_text = {group_text, alphabet_char({c2[3:0], b[7:6]})};
            group_text = {group_text, alphabet_char(b[5:0])};
            line_chars = line_chars + 8'd4;
            if (line_chars >= thr)
            begin
                push_line_end();
                line_chars = 8'd0;
            end
            held_cnt = 2'd0;
            held_pair = 16'h0000;
            if (fin)
                push_line_end();
        end
        else if (fin)
        begin
            // padded tail group: not counted, never wraps
            if (held_cnt == 2'd0)
            begin
                group_text = {group_text, alphabet_char(b[7:2])};
                group_text = {group_text, alphabet_char({b[1:0], 4'h0})};
                group_text = {group_text, PAD_CHAR};
                group_text = {group_text, PAD_CHAR};
            end
            else
            begin
                group_text = {group_text, alphabet_char(c1[7:2])};
                group_text = {group_text, alphabet_char({c1[1:0], b[7:4]})};
                group_text = {group_text, alphabet_char({b[3:0], 2'b00})};
                group_text = {group_text, PAD_CHAR};
            end
            push_line_end();
        end
        else
        begin
            // byte is only held, nothing comes out
            if (held_cnt == 2'd0)
                held_pair = {b, 8'h00};
            else
                held_pair[7:0] = b;
            held_cnt = held_cnt + 2'd1;
        end
        if (fin)
        begin
            held_pair = 16'h0000;
            held_cnt = 2'd0;
            line_chars = 8'd0;
        end
        // a typed-in expectation replaces the predicted text
        if (known.len() > 0)
        begin
            group_text.delete();
            for (i = 0; i < known.len(); i++)
                group_text = {group_text, known[i]};
        end
        for (i = 0; i < group_text.size(); i++)
        begin
            w.ch = group_text[i];
            w.last = (i == group_text.size() - 1);
            w.msg_end = fin && (i == group_text.size() - 1);
            chars_due = {chars_due, w};
        end
    endtask

    // offer one byte, hold it until accepted, then maybe pause
    task automatic send_byte(input logic [7:0] b, input logic fin, input string known);
        in_valid <= 1'b1;
        data_byte <= b;
        final_byte <= fin;
        do
            @(posedge clk);
        while (in_stall);
        encode_byte(b, fin, known);
        if (gap_max > 0)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
                burst_left = $urandom_range(1, 10);
            end
            else
                burst_left--;
        end
    endtask

    // let every due word drain, then give a held byte time to settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (chars_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_LINE_LIMIT)
            wrap_limit = v;
        else
            crlf_on = v[0];
    endtask

    task automatic add_row(input row_kind_e k, input logic [7:0] v, input logic f,
                           input string known);
        stim_row_t r;
        r.kind = k;
        r.val = v;
        r.flag = f;
        stim_rows = {stim_rows, r};
        stim_text = {stim_text, known};
    endtask

    // receiver: check each accepted word, stall on a shifting duty cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (chars_due.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected word: char %h last %b end %b",
                             out_char, run_last, message_end);
            end
            else
            begin
                if (out_char !== chars_due[0].ch || run_last !== chars_due[0].last ||
                    message_end !== chars_due[0].msg_end)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp char %h last %b end %b, got %h %b %b",
                                 chars_due[0].ch, chars_due[0].last, chars_due[0].msg_end,
                                 out_char, run_last, message_end);
                end
                void'(chars_due.pop_front());
            end
        end
        stall_phase++;
        if (stall_phase == 50)
        begin
            stall_phase = 0;
            case ($urandom_range(0, 4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 25;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial
    begin
        int i;
        int sent;
        int msgs;
        int len;
        int sel;
        logic [7:0] lim;

        held_pair = 16'h0000;
        held_cnt = 2'd0;
        line_chars = 8'd0;
        wrap_limit = LINE_LIMIT_RESET;
        crlf_on = EOL_MODE_RESET;

        // directed table
        add_row(ROW_BYTE, 8'h4D, 1'b1, "TQ==\015\012");
        add_row(ROW_BYTE, 8'h4D, 1'b0, "");
        add_row(ROW_BYTE, 8'h61, 1'b1, "TWE=\015\012");
        add_row(ROW_BYTE, 8'h4D, 1'b0, "");
        add_row(ROW_BYTE, 8'h61, 1'b0, "");
        add_row(ROW_BYTE, 8'h6E, 1'b1, "TWFu\015\012");
        add_row(ROW_REG,  8'h00, REG_EOL_MODE, "");
        add_row(ROW_BYTE, 8'h00, 1'b1, "AA==\012");
        add_row(ROW_BYTE, 8'hFF, 1'b0, "");
        add_row(ROW_BYTE, 8'hFF, 1'b0, "");
        add_row(ROW_BYTE, 8'hFF, 1'b1, "////\012");
        add_row(ROW_BYTE, 8'h00, 1'b0, "");
        add_row(ROW_BYTE, 8'h00, 1'b0, "");
        add_row(ROW_BYTE, 8'h00, 1'b0, "AAAA");
        add_row(ROW_BYTE, 8'hFF, 1'b1, "/w==\012");
        // wrap right before the closing line end
        add_row(ROW_REG,  8'd7,  REG_LINE_LIMIT, "");
        add_row(ROW_BYTE, 8'hFB, 1'b0, "");
        add_row(ROW_BYTE, 8'hEF, 1'b0, "");
        add_row(ROW_BYTE, 8'hBE, 1'b1, "++++\012\012");
        // limit below three: wrap after every group
        add_row(ROW_REG,  8'h01, REG_EOL_MODE, "");
        add_row(ROW_REG,  8'd0,  REG_LINE_LIMIT, "");
        add_row(ROW_BYTE, 8'h01, 1'b0, "");
        add_row(ROW_BYTE, 8'h02, 1'b0, "");
        add_row(ROW_BYTE, 8'h03, 1'b0, "");
        add_row(ROW_BYTE, 8'h04, 1'b1, "");

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < stim_rows.size(); i++)
        begin
            if (stim_rows[i].kind == ROW_REG)
                write_reg(stim_rows[i].flag, stim_rows[i].val);
            else
                send_byte(stim_rows[i].val, stim_rows[i].flag, stim_text[i]);
        end

        // random phases; the first one fills a line at the default limit
        sent = 0;
        sel = 0;
        while (sent < 100)
        begin
            if (sel == 0)
                lim = LINE_LIMIT_RESET;
            else
            begin
                case ($urandom_range(0, 5))
                    0:       lim = 8'($urandom_range(0, 3));
                    1:       lim = 8'd4;
                    2:       lim = 8'd255;
                    default: lim = 8'($urandom_range(5, 40));
                endcase
            end
            write_reg(REG_LINE_LIMIT, lim);
            write_reg(REG_EOL_MODE, 8'($urandom_range(0, 1)));
            gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            burst_left = 0;
            msgs = $urandom_range(1, 3);
            repeat (msgs)
            begin
                len = (sel == 0) ? 60 : $urandom_range(1, 14);
                sel = 1;
                for (i = 0; i < len; i++)
                    send_byte(8'($urandom_range(0, 255)), i == len - 1, "");
                sent += len;
            end
        end

        in_valid <= 1'b0;
        while (chars_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && chars_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
